### rtl/dctq_pkg.sv
// Shared types and constants for the delayed command timer queue.
`default_nettype none
package dctq_pkg;

  localparam int TICK_W      = 32;
  localparam int HANDLE_W    = 16;
  localparam int LATE_W      = 31;
  localparam int FUNC_W      = 3;
  localparam int IN_TDATA_W  = 88;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_AW      = 1;
  localparam int CFG_DW      = 1;

  typedef logic [FUNC_W-1:0] func_t;

  localparam func_t FN_ADD       = 3'd0;
  localparam func_t FN_FRAME     = 3'd1;
  localparam func_t FN_CLEAR     = 3'd2;
  localparam func_t FN_PAUSE     = 3'd3;
  localparam func_t FN_SET_DELAY = 3'd4;
  localparam func_t FN_ACTIVATE  = 3'd5;
  localparam func_t FN_RESTORE   = 3'd6;
  localparam func_t FN_PAUSE_CHG = 3'd7;

  typedef logic [CFG_AW-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEGACY_AWAIT = 1'd0;
  localparam cfg_idx_t CFG_CLEAR_ON_ACT = 1'd1;

  localparam logic [LATE_W-1:0] LATE_MAX = {LATE_W{1'b1}};

  localparam logic STATUS_FIRED   = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  // controller -> output stage
  typedef struct packed {
    logic                push;
    logic                flush;
    logic [HANDLE_W-1:0] handle;
    logic [LATE_W-1:0]   late;
    logic                status;
  } emit_t;

  // output stage -> controller
  typedef struct packed {
    logic push_ok;
    logic flush_done;
    logic hold_valid;
  } oq_stat_t;

endpackage
`default_nettype wire

### rtl/dctq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dctq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/dctq_outq.sv
// Result hold register and output register; the hold stage defers tlast until the run ends.
`default_nettype none
module dctq_outq
  import dctq_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire emit_t                  emit,
  output oq_stat_t                    st,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,   // fired_handle[15:0], late_by[46:16], pad
  output logic [0:0]                  out_tuser,   // status[0]
  output logic                        out_tlast    // last_of_run
);

  logic                hv_r;
  logic [HANDLE_W-1:0] h_hnd_r;
  logic [LATE_W-1:0]   h_late_r;
  logic                h_stat_r;

  logic                ov_r;
  logic [HANDLE_W-1:0] o_hnd_r;
  logic [LATE_W-1:0]   o_late_r;
  logic                o_stat_r;
  logic                o_last_r;

  logic out_free;

  assign out_free      = !ov_r || out_tready;
  assign st.push_ok    = !hv_r || out_free;
  assign st.flush_done = !hv_r || out_free;
  assign st.hold_valid = hv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (emit.push && st.push_ok) begin
      // a newer result arrived, so the held one is not the last
      h_hnd_r  <= emit.handle;
      h_late_r <= emit.late;
      h_stat_r <= emit.status;
      hv_r     <= 1'b1;
      if (hv_r) begin
        o_hnd_r  <= h_hnd_r;
        o_late_r <= h_late_r;
        o_stat_r <= h_stat_r;
        o_last_r <= 1'b0;
        ov_r     <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end else if (emit.flush && hv_r && out_free) begin
      o_hnd_r  <= h_hnd_r;
      o_late_r <= h_late_r;
      o_stat_r <= h_stat_r;
      o_last_r <= 1'b1;
      ov_r     <= 1'b1;
      hv_r     <= 1'b0;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {1'b0, o_late_r, o_hnd_r};
  assign out_tuser  = o_stat_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

### rtl/dctq_ctrl.sv
// Event decoder, queue state and the read-modify-write walk over the entry RAM.
`default_nettype none
module dctq_ctrl
  import dctq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int HANDLE_BITS = 16,
  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int CW = $clog2(QUEUE_DEPTH + 1),
  localparam int EW = TICK_W + HANDLE_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [CFG_AW-1:0] cfg_addr,
  input  wire logic [CFG_DW-1:0] cfg_wdata,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire func_t             in_func,
  input  wire logic [TICK_W-1:0] in_amount,
  input  wire logic [HANDLE_W-1:0] in_handle,
  input  wire logic [TICK_W-1:0] in_host,
  input  wire logic              in_pstate,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output logic [EW-1:0]          ram_wdata,
  output logic [AW-1:0]          ram_raddr,
  input  wire logic [EW-1:0]     ram_rdata,
  output emit_t                  emit,
  input  wire oq_stat_t          oq_st
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH
  } state_t;

  state_t            state_r;
  logic [CW-1:0]     cnt_r;
  logic [CW-1:0]     e_r;
  logic [CW-1:0]     w_r;
  logic              paused_r;
  logic [TICK_W-1:0] delay_r;
  logic [TICK_W-1:0] prev_r;
  logic [TICK_W-1:0] diff_r;
  logic              legacy_r;
  logic              clr_act_r;

  logic              accept;
  logic              full;
  logic              delay_pos;
  logic [TICK_W-1:0] diff;
  logic [31:0]       in_h32;
  logic [31:0]       in_hm32;
  logic [31:0]       cur_h32;
  logic [HANDLE_BITS-1:0] cur_hnd;
  logic [TICK_W-1:0] cur_cd;
  logic [TICK_W-1:0] new_cd;
  logic [TICK_W-1:0] neg_cd;
  logic [LATE_W-1:0] late;
  logic              fire;
  logic              walk_done;
  logic              walking;
  logic              stall;
  logic [CW-1:0]     e_inc;
  logic [CW-1:0]     rd_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign full      = (cnt_r == CW'(QUEUE_DEPTH));
  assign delay_pos = !delay_r[TICK_W-1] && (delay_r != '0);
  assign diff      = in_host - prev_r;

  // handles are kept in their low HANDLE_BITS bits
  always_comb begin
    in_h32                     = 32'(in_handle);
    in_hm32                    = '0;
    in_hm32[HANDLE_BITS-1:0]   = in_h32[HANDLE_BITS-1:0];
    cur_hnd                    = ram_rdata[EW-1:TICK_W];
    cur_h32                    = '0;
    cur_h32[HANDLE_BITS-1:0]   = cur_hnd;
  end

  assign cur_cd    = ram_rdata[TICK_W-1:0];
  assign new_cd    = cur_cd - diff_r;
  assign neg_cd    = '0 - new_cd;
  assign fire      = new_cd[TICK_W-1] || (new_cd == '0);
  // only the most negative count overflows the 31-bit field
  assign late      = (new_cd == {1'b1, {(TICK_W-1){1'b0}}}) ? LATE_MAX : neg_cd[LATE_W-1:0];
  assign walk_done = (e_r == cnt_r);
  assign walking   = (state_r == S_WALK) && !walk_done;
  assign stall     = walking && fire && !oq_st.push_ok;
  assign e_inc     = e_r + 1'b1;
  assign rd_idx    = stall ? e_r : e_inc;

  always_comb begin
    emit.flush = (state_r == S_FLUSH);
    if (state_r == S_IDLE) begin
      emit.push   = accept && (in_func == FN_ADD) && full;
      emit.handle = in_hm32[HANDLE_W-1:0];
      emit.late   = '0;
      emit.status = STATUS_DROPPED;
    end else begin
      emit.push   = walking && fire && oq_st.push_ok;
      emit.handle = cur_h32[HANDLE_W-1:0];
      emit.late   = late;
      emit.status = STATUS_FIRED;
    end
  end

  always_comb begin
    if (state_r == S_IDLE) begin
      ram_we    = accept && (in_func == FN_ADD) && !full;
      ram_waddr = cnt_r[AW-1:0];
      ram_wdata = {in_hm32[HANDLE_BITS-1:0], in_amount};
      ram_raddr = '0;   // primes entry 0 for a walk that starts next cycle
    end else begin
      ram_we    = walking && !fire;
      ram_waddr = w_r[AW-1:0];
      ram_wdata = {cur_hnd, new_cd};
      ram_raddr = rd_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      e_r       <= '0;
      w_r       <= '0;
      paused_r  <= 1'b0;
      delay_r   <= '0;
      prev_r    <= '0;
      legacy_r  <= 1'b0;
      clr_act_r <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LEGACY_AWAIT: legacy_r  <= cfg_wdata[0];
          CFG_CLEAR_ON_ACT: clr_act_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_func)
              FN_ADD: begin
                if (full) begin
                  state_r <= S_FLUSH;
                end else begin
                  cnt_r <= cnt_r + 1'b1;
                end
              end
              FN_FRAME: begin
                prev_r <= in_host;
                if (!paused_r) begin
                  if (delay_pos) begin
                    delay_r <= delay_r - diff;
                  end else if (cnt_r != '0) begin
                    diff_r  <= diff;
                    e_r     <= '0;
                    w_r     <= '0;
                    state_r <= S_WALK;
                  end
                end
              end
              FN_CLEAR:     cnt_r    <= '0;
              FN_PAUSE:     paused_r <= 1'b1;
              FN_SET_DELAY: delay_r  <= in_amount;
              FN_ACTIVATE: begin
                if (clr_act_r) cnt_r <= '0;
              end
              FN_RESTORE: begin
                if (legacy_r) paused_r <= 1'b0;
              end
              FN_PAUSE_CHG: begin
                if (!in_pstate && !legacy_r) paused_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (walk_done) begin
            cnt_r   <= w_r;
            state_r <= S_FLUSH;
          end else if (!stall) begin
            e_r <= e_inc;
            if (!fire) w_r <= w_r + 1'b1;
          end
        end
        S_FLUSH: begin
          if (oq_st.flush_done) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### rtl/delayed_command_timer_queue_unit.sv
// Delayed command timer queue: top level with entry RAM, controller and output stage.
//
// Usage: events arrive as requests on the in_ channel (in_tuser = func). Add queues a
// handle with a tick countdown; a frame request carries the host tick count and counts
// every entry down by the elapsed ticks (unless paused or a positive delay absorbs them).
// Fired commands leave on the out_ channel in insertion order with their lateness; the
// final result caused by one request has out_tlast set. An add to a full table returns
// a single result with out_tuser = 1 (dropped).
// Timing: a dropped add also passes through the flush state. A frame request is paced
// by the walk that reads, updates and writes back one RAM entry per cycle while no stall
// holds it. Each result is held back one step so tlast can be set: it enters the output
// register when the next result of the same request is produced, or in the flush state
// that ends the request for the last one, and shows on out_tvalid the cycle after that.
// Stalls: a result waits in the output register while out_tready is low, with one more
// held behind it; a further firing entry stops the walk until the receiver takes one.
// A new request is taken once the previous one has moved its last result into the
// output register; that result may still be waiting there.
// Reset (rst_n low, synchronous) empties the table at once, clears pause, delay and the
// recorded tick count and restores the register defaults; there is no clearing pass.
// The user must write the registers via cfg_we/cfg_addr/cfg_wdata only while the block is idle.
`default_nettype none
module delayed_command_timer_queue_unit
  import dctq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 32,
  parameter int HANDLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,  // tick_amount[31:0], command_handle[47:32],
                                                 // host_ticks[79:48], pause_state[80], pad
  input  wire logic [FUNC_W-1:0]      in_tuser,  // func[2:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata, // fired_handle[15:0], late_by[46:16], pad
  output logic [0:0]                  out_tuser, // status[0]
  output logic                        out_tlast, // last_of_run
  input  wire logic                   cfg_we,
  input  wire logic [CFG_AW-1:0]      cfg_addr,
  input  wire logic [CFG_DW-1:0]      cfg_wdata
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int EW = TICK_W + HANDLE_BITS;

  emit_t         emit_s;
  oq_stat_t      oq_st_s;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  dctq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  dctq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_func   (in_tuser),
    .in_amount (in_tdata[31:0]),
    .in_handle (in_tdata[47:32]),
    .in_host   (in_tdata[79:48]),
    .in_pstate (in_tdata[80]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .emit      (emit_s),
    .oq_st     (oq_st_s)
  );

  dctq_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit_s),
    .st         (oq_st_s),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // a result is only offered when the output stage can take it
  a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
    emit_s.push |-> oq_st_s.push_ok)
    else $error("result pushed into a full output stage");

  // each walked entry is either kept (written back) or fired, never both
  a_keep_or_fire: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !emit_s.push)
    else $error("entry written back and fired in the same cycle");

  // a new request starts only once the previous run is fully handed over
  a_accept_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !oq_st_s.hold_valid)
    else $error("request accepted with a result still held");

  // the hold register empties only by passing its result on as the last of its run
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(oq_st_s.hold_valid) |-> (out_tvalid && out_tlast))
    else $error("held result dropped or not marked last");

endmodule
`default_nettype wire
